// ===== hw/rtl/lfc_pkg.sv =====
`default_nettype none

package lfc_pkg;

    localparam int MAX_DATA = 8;

    // Frame position: 0 sync, 1 protected ID, 2 plus the number of data bytes taken.
    localparam int POS_W = $clog2(MAX_DATA + 3);

    localparam logic [POS_W-1:0] POS_SYNC  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_PID   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_DATA0 = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_DATA + 2);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ID          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_FRAME_ID = 2'd2;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_VERDICT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_LENGTH   = 2'd1,
        STATUS_ID       = 2'd2,
        STATUS_CHECKSUM = 2'd3
    } t_status;

    typedef struct packed {
        logic       checksum_mode;
        logic       check_id;
        logic [5:0] expected_frame_id;
    } t_cfg;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload_byte;
        t_status    status;
    } t_result;

    // Frame identifier with its two parity bits in bits 6 and 7.
    function automatic logic [7:0] protected_id(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    // Eight-bit add with end-around carry.
    function automatic logic [7:0] add_carry(input logic [7:0] acc, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, acc} + {1'b0, b};
        return s[7:0] + {7'b0, s[8]};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lfc_core.sv =====
`default_nettype none

module lfc_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_rx_byte,
    input  wire logic            i_frame_end,
    input  wire lfc_pkg::t_cfg   i_cfg,
    output lfc_pkg::t_result     o_result
);
    import lfc_pkg::*;

    logic [POS_W-1:0] r_pos,      n_pos;
    logic [7:0]       r_sum,      n_sum;
    logic             r_id_bad,   n_id_bad;
    logic             r_too_long, n_too_long;

    always_comb begin
        n_pos               = r_pos;
        n_sum               = r_sum;
        n_id_bad            = r_id_bad;
        n_too_long          = r_too_long;
        o_result.kind         = KIND_HEADER;
        o_result.payload_byte = 8'd0;
        o_result.status       = STATUS_OK;
        if (i_frame_end) begin
            o_result.kind = KIND_VERDICT;
            if (r_pos < POS_DATA0 || r_too_long) begin
                o_result.status = STATUS_LENGTH;
            end else if (r_id_bad) begin
                o_result.status = STATUS_ID;
            end else if (i_rx_byte != ~r_sum) begin
                o_result.status = STATUS_CHECKSUM;
            end
            n_pos      = POS_SYNC;
            n_sum      = 8'd0;
            n_id_bad   = 1'b0;
            n_too_long = 1'b0;
        end else if (r_pos == POS_SYNC) begin
            n_pos = POS_PID;
        end else if (r_pos == POS_PID) begin
            n_id_bad = i_cfg.check_id &&
                       (i_rx_byte != protected_id(i_cfg.expected_frame_id));
            n_sum    = i_cfg.checksum_mode ? i_rx_byte : 8'd0;
            n_pos    = POS_DATA0;
        end else if (r_pos < POS_LIMIT) begin
            n_sum                 = add_carry(r_sum, i_rx_byte);
            n_pos                 = r_pos + POS_W'(1);
            o_result.kind         = KIND_PAYLOAD;
            o_result.payload_byte = i_rx_byte;
        end else begin
            // Surplus data beats are dropped and spoil the verdict.
            n_too_long = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= POS_SYNC;
            r_sum      <= 8'd0;
            r_id_bad   <= 1'b0;
            r_too_long <= 1'b0;
        end else if (i_accept) begin
            r_pos      <= n_pos;
            r_sum      <= n_sum;
            r_id_bad   <= n_id_bad;
            r_too_long <= n_too_long;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lin_frame_checker.sv =====
`default_nettype none

// LIN frame checker. Each received byte enters as one beat on the slave stream, with
// tlast marking the checksum byte, and yields exactly one beat on the master stream in
// the next cycle: tuser gives the kind (header or dropped byte, payload byte, or verdict),
// the low tdata byte carries payload bytes and tdata bits 9:8 the verdict status. One
// beat is taken every cycle unless stalled; the single output register is the only
// storage between the streams, so tready falls only while that register holds a beat
// that is not taken. Checksum mode and the ID check are sampled when the protected ID
// byte arrives; write the configuration registers only between frames while the block is idle.
module lin_frame_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [lfc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [lfc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,  // rx_byte
    input  wire logic                            s_axis_tlast,  // frame_end
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [15:0]                          m_axis_tdata,  // payload_byte, status
    output logic [1:0]                           m_axis_tuser   // kind
);
    import lfc_pkg::*;

    t_cfg    r_cfg;
    t_result w_result;
    t_result r_out;
    logic    r_out_valid;
    logic    w_accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.checksum_mode     <= 1'b1;
            r_cfg.check_id          <= 1'b0;
            r_cfg.expected_frame_id <= 6'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHECKSUM_MODE:     r_cfg.checksum_mode     <= i_cfg_data[0];
                CFG_CHECK_ID:          r_cfg.check_id          <= i_cfg_data[0];
                CFG_EXPECTED_FRAME_ID: r_cfg.expected_frame_id <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lfc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_rx_byte   (s_axis_tdata),
        .i_frame_end (s_axis_tlast),
        .i_cfg       (r_cfg),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.status, r_out.payload_byte};
    assign m_axis_tuser  = r_out.kind;

endmodule

`default_nettype wire

// ===== hw/rtl/lin_frame_checker_chk.sv =====
`default_nettype none

module lin_frame_checker_chk (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic        s_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [15:0] m_axis_tdata,
    input  wire logic [1:0]  m_axis_tuser
);
    import lfc_pkg::*;

    // A beat that is not taken keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // Every accepted input beat appears as an output beat in the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted beat produced no result");

    // The checksum byte, and only it, gives a verdict.
    a_verdict_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=>
            ((m_axis_tuser == KIND_VERDICT) == $past(s_axis_tlast)))
        else $error("verdict does not match end of frame");

    // Status is zero outside verdicts, payload is zero outside payload beats.
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tuser == KIND_VERDICT || m_axis_tdata[9:8] == 2'd0) &&
            (m_axis_tuser == KIND_PAYLOAD || m_axis_tdata[7:0] == 8'd0))
        else $error("unused output field not zero");

endmodule

bind lin_frame_checker lin_frame_checker_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
